// File: rtl/core/bpc_pkg.sv
// ============================================================================
// bpc_pkg
// Shared types and constants for the barometric pressure compensation core.
// ============================================================================
package bpc_pkg;

    // Width of the pipelined divider datapath and its latency in cycles.
    localparam int DIV_W   = 32;
    localparam int DIV_LAT = DIV_W + 1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_GROUP_A  = 3'd0;
    localparam logic [2:0] CFG_GROUP_B  = 3'd1;
    localparam logic [2:0] CFG_GROUP_C  = 3'd2;
    localparam logic [2:0] CFG_GROUP_D  = 3'd3;
    localparam logic [2:0] CFG_OVERSAMP = 3'd4;

    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;

    // Compensation constants.
    localparam logic signed [31:0] T_ROUND    = 32'sd8;
    localparam logic signed [31:0] B6_OFFSET  = 32'sd4000;
    localparam logic signed [31:0] B4_BIAS    = 32'sd32768;
    localparam logic [15:0]        B7_SCALE   = 16'd50000;
    localparam logic [31:0]        B7_SPLIT   = 32'h8000_0000;
    localparam logic signed [31:0] P_COEF_SQ  = 32'sd3038;
    localparam logic signed [31:0] P_COEF_LIN = -32'sd7357;
    localparam logic signed [31:0] P_COEF_OFS = 32'sd3791;
    localparam logic signed [31:0] P_MAX      = 32'sd262143;
    localparam logic signed [31:0] TEMP_MAX   = 32'sd32767;
    localparam logic signed [31:0] TEMP_MIN   = -32'sd32768;

    // Input word: one raw reading pair.
    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [18:0] raw_pressure;
    } t_in_word;

    // Output word: compensated results.
    typedef struct packed {
        logic [17:0]        pressure_pa;
        logic signed [15:0] temperature_tenths;
        logic               divide_fault;
    } t_out_word;

endpackage

// File: rtl/core/bpc_div.sv
// ============================================================================
// bpc_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ============================================================================
module bpc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [bpc_pkg::DIV_W-1:0]   i_dividend,
    input  logic [bpc_pkg::DIV_W-1:0]   i_divisor,
    output logic                        o_valid,
    output logic [bpc_pkg::DIV_W-1:0]   o_quotient
);
    import bpc_pkg::*;

    logic             r_vld [0:DIV_W];
    logic [DIV_W-1:0] r_num [0:DIV_W];
    logic [DIV_W-1:0] r_rem [0:DIV_W-1];
    logic [DIV_W-1:0] r_dvs [0:DIV_W-1];

    logic [DIV_W:0]   w_try  [0:DIV_W-1];
    logic [DIV_W:0]   w_diff [0:DIV_W-1];
    logic [DIV_W-1:0] w_ge;

    // One trial subtraction per stage.
    always_comb begin
        for (int k = 0; k < DIV_W; k++) begin
            w_try[k]  = {r_rem[k], r_num[k][DIV_W-1]};
            w_diff[k] = w_try[k] - {1'b0, r_dvs[k]};
            w_ge[k]   = !w_diff[k][DIV_W];
        end
    end

    // Valid bits travel with the operands.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_W; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= DIV_W; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Capture the operands; quotient bits shift in at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= i_dividend;
            r_rem[0] <= '0;
            r_dvs[0] <= i_divisor;
            for (int k = 0; k < DIV_W; k++) begin
                r_num[k+1] <= {r_num[k][DIV_W-2:0], w_ge[k]};
            end
            for (int k = 0; k < DIV_W-1; k++) begin
                r_rem[k+1] <= w_ge[k] ? w_diff[k][DIV_W-1:0] : w_try[k][DIV_W-1:0];
                r_dvs[k+1] <= r_dvs[k];
            end
        end
    end

    assign o_valid    = r_vld[DIV_W];
    assign o_quotient = r_num[DIV_W];

endmodule

// File: rtl/core/barometric_pressure_compensation_core.sv
// ============================================================================
// barometric_pressure_compensation_core
// Integer pressure and temperature compensation for a calibrated barometer.
// ============================================================================
// The core takes one word per cycle while not stalled and returns one result
// word for each, in order. The path runs through the two pipelined dividers
// (temperature term and pressure quotient) plus 15 arithmetic stages. The
// whole pipeline advances together; it halts only while the output word is
// held by a stall, and then the input is stalled as well.
// Calibration words and the oversampling setting must be written while no
// word is in flight.
module barometric_pressure_compensation_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  bpc_pkg::t_in_word               i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output bpc_pkg::t_out_word              o_out_word,
    input  logic                            i_cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bpc_pkg::*;

    typedef struct packed {
        logic signed [31:0] x1;
        logic [18:0]        up;
        logic               neg;
        logic               fault;
    } t_ctx_t;

    typedef struct packed {
        logic signed [15:0] temp;
        logic               fault;
        logic               big;
    } t_ctx_p;

    // ------------------------------------------------------------------
    // Configuration registers.
    logic [47:0] r_cal_a;
    logic [47:0] r_cal_b;
    logic [31:0] r_cal_c;
    logic [31:0] r_cal_d;
    logic [1:0]  r_oss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
            r_cal_d <= '0;
            r_oss   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GROUP_A:  r_cal_a <= i_cfg_data;
                CFG_GROUP_B:  r_cal_b <= i_cfg_data;
                CFG_GROUP_C:  r_cal_c <= i_cfg_data[31:0];
                CFG_GROUP_D:  r_cal_d <= i_cfg_data[31:0];
                CFG_OVERSAMP: r_oss   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Calibration words as 32-bit values.
    logic signed [31:0] w_ac1, w_ac2, w_ac3, w_b1, w_b2, w_mc, w_md;
    logic [15:0]        w_ac4, w_ac5, w_ac6;

    assign w_ac1 = 32'(signed'(r_cal_a[15:0]));
    assign w_ac2 = 32'(signed'(r_cal_a[31:16]));
    assign w_ac3 = 32'(signed'(r_cal_a[47:32]));
    assign w_ac4 = r_cal_b[15:0];
    assign w_ac5 = r_cal_b[31:16];
    assign w_ac6 = r_cal_b[47:32];
    assign w_b1  = 32'(signed'(r_cal_c[15:0]));
    assign w_b2  = 32'(signed'(r_cal_c[31:16]));
    assign w_mc  = 32'(signed'(r_cal_d[15:0]));
    assign w_md  = 32'(signed'(r_cal_d[31:16]));

    // Global advance: everything moves unless the output word is held.
    logic r_out_vld;
    logic w_en;

    assign w_en       = !r_out_vld || !i_out_stall;
    assign o_in_stall = !w_en;

    // ------------------------------------------------------------------
    // Stage A: capture input, temperature difference.
    logic               r_a_vld;
    logic signed [16:0] r_a_diff;
    logic [18:0]        r_a_up;

    // Stage B: difference times ac5.
    logic               r_b_vld;
    logic signed [33:0] r_b_prod;
    logic [18:0]        r_b_up;

    // Stage C: x1 and the temperature divisor.
    logic               r_c_vld;
    logic signed [31:0] r_c_x1;
    logic signed [31:0] r_c_den;
    logic [18:0]        r_c_up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_in_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    logic signed [31:0] w_b_x1;
    assign w_b_x1 = signed'(r_b_prod[31:0]) >>> 15;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_diff <= signed'({1'b0, i_in_word.raw_temperature})
                      - signed'({1'b0, w_ac6});
            r_a_up   <= i_in_word.raw_pressure;
            r_b_prod <= 34'(r_a_diff) * 34'(signed'({1'b0, w_ac5}));
            r_b_up   <= r_a_up;
            r_c_x1   <= w_b_x1;
            r_c_den  <= w_b_x1 + w_md;
            r_c_up   <= r_b_up;
        end
    end

    // ------------------------------------------------------------------
    // Temperature division: (mc * 2048) / (x1 + md), truncating.
    logic signed [31:0] w_num_t;
    logic [31:0]        w_num_mag;
    logic [31:0]        w_den_mag;
    logic               w_d1_vld;
    logic [31:0]        w_d1_q;
    t_ctx_t             w_ctx_t_in;
    t_ctx_t             r_ctx_t [0:DIV_LAT-1];

    assign w_num_t   = w_mc <<< 11;
    assign w_num_mag = w_num_t[31] ? 32'(-w_num_t) : 32'(w_num_t);
    assign w_den_mag = r_c_den[31] ? 32'(-r_c_den) : 32'(r_c_den);

    assign w_ctx_t_in.x1    = r_c_x1;
    assign w_ctx_t_in.up    = r_c_up;
    assign w_ctx_t_in.neg   = w_num_t[31] ^ r_c_den[31];
    assign w_ctx_t_in.fault = (r_c_den == 32'sd0);

    bpc_div u_div_t (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_c_vld),
        .i_dividend (w_num_mag),
        .i_divisor  (w_den_mag),
        .o_valid    (w_d1_vld),
        .o_quotient (w_d1_q)
    );

    // Side data rides alongside the divider.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ctx_t[0] <= w_ctx_t_in;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_ctx_t[k] <= r_ctx_t[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage E: b5. Stage F: temperature and b6.
    logic               r_e_vld, r_f_vld;
    logic signed [31:0] r_e_b5;
    logic               r_e_fault, r_f_fault;
    logic [18:0]        r_e_up, r_f_up;
    logic signed [15:0] r_f_temp;
    logic signed [31:0] r_f_b6;

    logic signed [31:0] w_e_x2;
    logic signed [31:0] w_f_t1;
    logic signed [15:0] w_f_sat;

    assign w_e_x2 = r_ctx_t[DIV_LAT-1].neg ? -signed'(w_d1_q) : signed'(w_d1_q);
    assign w_f_t1 = (r_e_b5 + T_ROUND) >>> 4;

    always_comb begin
        priority if (w_f_t1 > TEMP_MAX) begin
            w_f_sat = 16'sd32767;
        end else if (w_f_t1 < TEMP_MIN) begin
            w_f_sat = -16'sd32768;
        end else begin
            w_f_sat = w_f_t1[15:0];
        end
    end

    // Stage G: squares and products of b6.
    logic               r_g_vld;
    logic signed [31:0] r_g_b6sq, r_g_ac2b6, r_g_ac3b6;
    logic signed [15:0] r_g_temp;
    logic               r_g_fault;
    logic [18:0]        r_g_up;

    // Stage H: t and scaled products.
    logic               r_h_vld;
    logic signed [31:0] r_h_t, r_h_x2a, r_h_x1b;
    logic signed [15:0] r_h_temp;
    logic               r_h_fault;
    logic [18:0]        r_h_up;

    // Stage I: b2*t and b1*t.
    logic               r_i_vld;
    logic signed [31:0] r_i_b2t, r_i_b1t, r_i_x2a, r_i_x1b;
    logic signed [15:0] r_i_temp;
    logic               r_i_fault;
    logic [18:0]        r_i_up;

    // Stage J: b3 and the x3 term of b4.
    logic               r_j_vld;
    logic signed [31:0] r_j_b3, r_j_x3;
    logic signed [15:0] r_j_temp;
    logic               r_j_fault;
    logic [18:0]        r_j_up;

    // Stage K: b4 product and up - b3.
    logic               r_k_vld;
    logic [31:0]        r_k_b4p, r_k_diff;
    logic signed [15:0] r_k_temp;
    logic               r_k_fault;

    // Stage L: b4 and b7.
    logic               r_l_vld;
    logic [16:0]        r_l_b4;
    logic [31:0]        r_l_b7;
    logic signed [15:0] r_l_temp;
    logic               r_l_fault;

    logic signed [31:0] w_j_x3a, w_j_v, w_j_x3b;
    logic [31:0]        w_k_base;
    logic [15:0]        w_l_scale;

    assign w_j_x3a   = (r_i_b2t >>> 11) + r_i_x2a;
    assign w_j_v     = ((w_ac1 <<< 2) + w_j_x3a) <<< r_oss;
    assign w_j_x3b   = (r_i_b1t >>> 16) + r_i_x1b + 32'sd2;
    assign w_k_base  = 32'(r_j_x3 + B4_BIAS);
    assign w_l_scale = B7_SCALE >> r_oss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
            r_i_vld <= 1'b0;
            r_j_vld <= 1'b0;
            r_k_vld <= 1'b0;
            r_l_vld <= 1'b0;
        end else if (w_en) begin
            r_e_vld <= w_d1_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
            r_h_vld <= r_g_vld;
            r_i_vld <= r_h_vld;
            r_j_vld <= r_i_vld;
            r_k_vld <= r_j_vld;
            r_l_vld <= r_k_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_b5    <= r_ctx_t[DIV_LAT-1].x1 + w_e_x2;
            r_e_fault <= r_ctx_t[DIV_LAT-1].fault;
            r_e_up    <= r_ctx_t[DIV_LAT-1].up;

            r_f_temp  <= r_e_fault ? 16'sd0 : w_f_sat;
            r_f_b6    <= r_e_b5 - B6_OFFSET;
            r_f_fault <= r_e_fault;
            r_f_up    <= r_e_up;

            r_g_b6sq  <= r_f_b6 * r_f_b6;
            r_g_ac2b6 <= w_ac2 * r_f_b6;
            r_g_ac3b6 <= w_ac3 * r_f_b6;
            r_g_temp  <= r_f_temp;
            r_g_fault <= r_f_fault;
            r_g_up    <= r_f_up;

            r_h_t     <= r_g_b6sq >>> 12;
            r_h_x2a   <= r_g_ac2b6 >>> 11;
            r_h_x1b   <= r_g_ac3b6 >>> 13;
            r_h_temp  <= r_g_temp;
            r_h_fault <= r_g_fault;
            r_h_up    <= r_g_up;

            r_i_b2t   <= w_b2 * r_h_t;
            r_i_b1t   <= w_b1 * r_h_t;
            r_i_x2a   <= r_h_x2a;
            r_i_x1b   <= r_h_x1b;
            r_i_temp  <= r_h_temp;
            r_i_fault <= r_h_fault;
            r_i_up    <= r_h_up;

            r_j_b3    <= (w_j_v + 32'sd2) >>> 2;
            r_j_x3    <= w_j_x3b >>> 2;
            r_j_temp  <= r_i_temp;
            r_j_fault <= r_i_fault;
            r_j_up    <= r_i_up;

            r_k_b4p   <= 32'(w_ac4) * w_k_base;
            r_k_diff  <= 32'(r_j_up) - 32'(r_j_b3);
            r_k_temp  <= r_j_temp;
            r_k_fault <= r_j_fault;

            r_l_b4    <= r_k_b4p[31:15];
            r_l_b7    <= r_k_diff * 32'(w_l_scale);
            r_l_temp  <= r_k_temp;
            r_l_fault <= r_k_fault;
        end
    end

    // ------------------------------------------------------------------
    // Pressure division with the split rule at the top bit of b7.
    logic        w_big;
    logic [31:0] w_num_p;
    logic        w_d2_vld;
    logic [31:0] w_d2_q;
    t_ctx_p      w_ctx_p_in;
    t_ctx_p      r_ctx_p [0:DIV_LAT-1];

    assign w_big   = (r_l_b7 >= B7_SPLIT);
    assign w_num_p = w_big ? r_l_b7 : (r_l_b7 << 1);

    assign w_ctx_p_in.temp  = r_l_temp;
    assign w_ctx_p_in.fault = r_l_fault || (r_l_b4 == 17'd0);
    assign w_ctx_p_in.big   = w_big;

    bpc_div u_div_p (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_l_vld),
        .i_dividend (w_num_p),
        .i_divisor  (32'(r_l_b4)),
        .o_valid    (w_d2_vld),
        .o_quotient (w_d2_q)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ctx_p[0] <= w_ctx_p_in;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_ctx_p[k] <= r_ctx_p[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Final pressure correction: stages M, N, O, then the output word.
    logic               r_m_vld, r_n_vld, r_o_vld;
    logic signed [31:0] r_m_p, r_m_sq, r_m_lin;
    logic signed [31:0] r_n_p, r_n_prod, r_n_x2;
    logic signed [31:0] r_o_p, r_o_sum;
    logic signed [15:0] r_m_temp, r_n_temp, r_o_temp;
    logic               r_m_fault, r_n_fault, r_o_fault;
    t_out_word          r_out;

    logic signed [31:0] w_m_p, w_m_x1, w_p_fin;
    logic [17:0]        w_p_sat;

    assign w_m_p   = r_ctx_p[DIV_LAT-1].big ? signed'(w_d2_q << 1) : signed'(w_d2_q);
    assign w_m_x1  = w_m_p >>> 8;
    assign w_p_fin = r_o_p + (r_o_sum >>> 4);

    always_comb begin
        priority if (w_p_fin < 32'sd0) begin
            w_p_sat = '0;
        end else if (w_p_fin > P_MAX) begin
            w_p_sat = P_MAX[17:0];
        end else begin
            w_p_sat = w_p_fin[17:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld   <= 1'b0;
            r_n_vld   <= 1'b0;
            r_o_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_m_vld   <= w_d2_vld;
            r_n_vld   <= r_m_vld;
            r_o_vld   <= r_n_vld;
            r_out_vld <= r_o_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_p     <= w_m_p;
            r_m_sq    <= w_m_x1 * w_m_x1;
            r_m_lin   <= P_COEF_LIN * w_m_p;
            r_m_temp  <= r_ctx_p[DIV_LAT-1].temp;
            r_m_fault <= r_ctx_p[DIV_LAT-1].fault;

            r_n_p     <= r_m_p;
            r_n_prod  <= r_m_sq * P_COEF_SQ;
            r_n_x2    <= r_m_lin >>> 16;
            r_n_temp  <= r_m_temp;
            r_n_fault <= r_m_fault;

            r_o_p     <= r_n_p;
            r_o_sum   <= (r_n_prod >>> 16) + r_n_x2 + P_COEF_OFS;
            r_o_temp  <= r_n_temp;
            r_o_fault <= r_n_fault;

            r_out.pressure_pa        <= r_o_fault ? 18'd0 : w_p_sat;
            r_out.temperature_tenths <= r_o_temp;
            r_out.divide_fault       <= r_o_fault;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

endmodule

// File: tb/sv/barometric_pressure_compensation_core_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// barometric_pressure_compensation_core_tb
// Self-checking bench for the pressure compensation core. Calibration sets
// are loaded while the pipeline is empty, reading pairs are streamed in with
// random gaps and output stalls, and each result word is compared field by
// field against an in-bench integer model of the compensation.
// ============================================================================
module barometric_pressure_compensation_core_tb;
    import bpc_pkg::*;

    // Tracks expected result words in order and counts mismatches.
    class compensation_scoreboard;
        logic [47:0] grp_a, grp_b;
        logic [31:0] grp_c, grp_d;
        logic [1:0]  oss;
        t_out_word   pending[$];
        int          fail_count;
        int          checked;
        int          faults_seen;

        function new();
            grp_a = '0; grp_b = '0; grp_c = '0; grp_d = '0; oss = '0;
            fail_count = 0; checked = 0; faults_seen = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [47:0] data);
            case (idx)
                CFG_GROUP_A: grp_a = data;
                CFG_GROUP_B: grp_b = data;
                CFG_GROUP_C: grp_c = data[31:0];
                CFG_GROUP_D: grp_d = data[31:0];
                CFG_OVERSAMP: oss = data[1:0];
                default: ;
            endcase
        endfunction

        // Computes the compensated pressure and temperature for one pair.
        function t_out_word compensate(t_in_word w);
            t_out_word r;
            logic signed [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
            logic signed [31:0] ut, x1, x2, x3, den, b5, b6, t, b3, p, temp;
            logic [31:0] up, b4, b7, pu;
            ac1 = 32'(signed'(grp_a[15:0]));
            ac2 = 32'(signed'(grp_a[31:16]));
            ac3 = 32'(signed'(grp_a[47:32]));
            ac4 = {16'd0, grp_b[15:0]};
            ac5 = {16'd0, grp_b[31:16]};
            ac6 = {16'd0, grp_b[47:32]};
            b1 = 32'(signed'(grp_c[15:0]));
            b2 = 32'(signed'(grp_c[31:16]));
            mc = 32'(signed'(grp_d[15:0]));
            md = 32'(signed'(grp_d[31:16]));
            ut = {16'd0, w.raw_temperature};
            up = {13'd0, w.raw_pressure};
            r = '0;
            x1 = ((ut - ac6) * ac5) >>> 15;
            den = x1 + md;
            if (den == 0) begin
                r.divide_fault = 1'b1;
                return r;
            end
            // Signed division truncates toward zero; only the wrap case overflows.
            x2 = 32'((64'(signed'(mc * 32'sd2048))) / 64'(den));
            b5 = x1 + x2;
            temp = (b5 + T_ROUND) >>> 4;
            if (temp > TEMP_MAX) temp = TEMP_MAX;
            if (temp < TEMP_MIN) temp = TEMP_MIN;
            r.temperature_tenths = temp[15:0];
            b6 = b5 - B6_OFFSET;
            t = (b6 * b6) >>> 12;
            x1 = (b2 * t) >>> 11;
            x2 = (ac2 * b6) >>> 11;
            x3 = x1 + x2;
            b3 = ((((ac1 * 32'sd4) + x3) << oss) + 32'sd2) >>> 2;
            x1 = (ac3 * b6) >>> 13;
            x2 = (b1 * t) >>> 16;
            x3 = (x1 + x2 + 32'sd2) >>> 2;
            b4 = (32'(ac4) * (32'(x3) + 32'd32768)) >> 15;
            if (b4 == 0) begin
                r.divide_fault = 1'b1;
                return r;
            end
            b7 = (up - 32'(b3)) * (32'd50000 >> oss);
            if (b7 < B7_SPLIT) pu = (b7 << 1) / b4;
            else pu = (b7 / b4) << 1;
            p = pu;
            x1 = p >>> 8;
            x1 = x1 * x1;
            x1 = (x1 * P_COEF_SQ) >>> 16;
            x2 = (P_COEF_LIN * p) >>> 16;
            p = p + ((x1 + x2 + P_COEF_OFS) >>> 4);
            if (p < 0) p = 0;
            if (p > P_MAX) p = P_MAX;
            r.pressure_pa = p[17:0];
            return r;
        endfunction

        function void note_input(t_in_word w);
            pending.push_back(compensate(w));
        endfunction

        function void check_result(t_out_word got);
            t_out_word exp_w;
            if (pending.size() == 0) begin
                $error("result word with nothing expected: %h", got);
                fail_count++;
                return;
            end
            exp_w = pending.pop_front();
            checked++;
            if (got.divide_fault) faults_seen++;
            if (got.pressure_pa !== exp_w.pressure_pa) begin
                $error("pressure_pa expected %0d actual %0d",
                       exp_w.pressure_pa, got.pressure_pa);
                fail_count++;
            end
            if (got.temperature_tenths !== exp_w.temperature_tenths) begin
                $error("temperature_tenths expected %0d actual %0d",
                       exp_w.temperature_tenths, got.temperature_tenths);
                fail_count++;
            end
            if (got.divide_fault !== exp_w.divide_fault) begin
                $error("divide_fault expected %0b actual %0b",
                       exp_w.divide_fault, got.divide_fault);
                fail_count++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_word    in_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_word   out_word;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [47:0] cfg_data = '0;

    compensation_scoreboard board = new();
    bit  quiet_tail = 1'b0;
    int  cycle_count = 0;
    int  words_sent = 0;
    localparam int CYCLE_LIMIT = 600000;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    barometric_pressure_compensation_core i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_word(in_word),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_word(out_word),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    // Result checking and random output stalls, in bursts.
    int stall_left = 0;
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) board.check_result(out_word);
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 17) - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_register(logic [2:0] idx, logic [47:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_register(idx, data);
    endtask

    // Sends one word, holding it until accepted, with an optional gap first.
    task automatic send_word(t_in_word w);
        int gap;
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_input(w);
        words_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic load_calibration(logic [47:0] a, logic [47:0] b,
                                    logic [31:0] c, logic [31:0] d, logic [1:0] o);
        write_register(CFG_GROUP_A, a);
        write_register(CFG_GROUP_B, b);
        write_register(CFG_GROUP_C, {16'd0, c});
        write_register(CFG_GROUP_D, {16'd0, d});
        write_register(CFG_OVERSAMP, {46'd0, o});
    endtask

    // A realistic calibration set (datasheet-like values).
    task automatic load_typical(logic [1:0] o);
        load_calibration({16'hC7B8, 16'hFB90, 16'h0198}, {16'd23153, 16'd32757, 16'd32741},
                         {16'd4, 16'd6190}, {16'd2868, 16'hD4BD}, o);
    endtask

    function automatic t_in_word plausible_word(logic [1:0] o);
        t_in_word w;
        w.raw_temperature = 16'($urandom_range(20000, 35000));
        w.raw_pressure = 19'($urandom_range(18000, 45000) << o);
        return w;
    endfunction

    function automatic t_in_word any_word();
        t_in_word w;
        w.raw_temperature = 16'($urandom);
        w.raw_pressure = 19'($urandom);
        return w;
    endfunction

    initial begin
        t_in_word w;
        logic [1:0] o;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset calibration: temperature divisor is zero, so every word faults.
        w = '0; send_word(w);
        w = '1; send_word(w);
        drain();

        // Typical set: field extremes, realistic readings, two-way division.
        load_typical(2'd0);
        w.raw_temperature = 16'd27898; w.raw_pressure = 19'd23843; send_word(w);
        w.raw_temperature = 16'd0;     w.raw_pressure = 19'd0;     send_word(w);
        w.raw_temperature = 16'hFFFF;  w.raw_pressure = 19'h7FFFF; send_word(w);
        w.raw_temperature = 16'd0;     w.raw_pressure = 19'h7FFFF; send_word(w);
        w.raw_temperature = 16'hFFFF;  w.raw_pressure = 19'd0;     send_word(w);
        w.raw_temperature = 16'h8000;  w.raw_pressure = 19'h40000; send_word(w);
        drain();

        // Temperature divisor zero with ac5 = 0 and md = 0.
        load_calibration({16'd1, 16'd1, 16'd1}, {16'd100, 16'd0, 16'd100},
                         {16'd1, 16'd1}, {16'd0, 16'd5}, 2'd3);
        w.raw_temperature = 16'd1234; w.raw_pressure = 19'd4321; send_word(w);
        drain();

        // Pressure divisor zero: ac4 = 0 with a valid temperature.
        load_calibration({16'd408, 16'hFFC4, 16'hC7B8}, {16'd23153, 16'd32757, 16'd0},
                         {16'd4, 16'd6190}, {16'hD4BD, 16'd2868}, 2'd1);
        w.raw_temperature = 16'd27898; w.raw_pressure = 19'd50000; send_word(w);
        drain();

        // Extreme calibration words: saturation and wrapping paths.
        load_calibration('1, '1, '1, {16'h7FFF, 16'h8000}, 2'd2);
        for (int i = 0; i < 6; i++) send_word(any_word());
        drain();
        load_calibration({16'h8000, 16'h7FFF, 16'h8000}, {16'hFFFF, 16'h0001, 16'hFFFF},
                         {16'h7FFF, 16'h8000}, {16'h0001, 16'h7FFF}, 2'd3);
        for (int i = 0; i < 6; i++) send_word(any_word());
        drain();

        // Random phases: mostly realistic calibration and readings, some noise.
        for (int ph = 0; ph < 12; ph++) begin
            o = 2'($urandom_range(0, 3));
            if (ph % 3 == 2)
                load_calibration(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                                 $urandom, $urandom, o);
            else
                load_typical(o);
            if (ph == 10) quiet_tail = 1'b1;
            for (int i = 0; i < 125; i++)
                send_word(($urandom_range(0, 4) == 0) ? any_word() : plausible_word(o));
            drain();
        end

        $display("Checked %0d result words over %0d sent, %0d with divide fault.",
                 board.checked, words_sent, board.faults_seen);
        if (board.fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
